>>> src/plas_pkg.sv
// Package for the polyline arc-length sampler: sizes, codes and state type.
// No dependencies; used by the top level in src and by the bench in dv.
package plas_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // segments no longer than 0.0001 in Q16.16 are skipped
  localparam logic [31:0] SHORT_SEG_RAW = 32'd6;

  localparam logic [5:0] DIV_STEPS  = 6'd33;
  localparam logic [5:0] SQRT_STEPS = 6'd32;
  localparam logic [1:0] AXIS_LAST  = 2'd2;

  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_APPEND  = 2'd1,
    FUNC_ADVANCE = 2'd2,
    FUNC_QUERY   = 2'd3
  } func_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADV_MUL,
    ST_ADV_UPD,
    ST_DIFF,
    ST_MUL,
    ST_ACC,
    ST_SQ_LD,
    ST_SQRT,
    ST_SEG_WR,
    ST_Q_RD,
    ST_Q_CHK,
    ST_Q_RDA,
    ST_Q_RDB,
    ST_Q_CAPB,
    ST_DIV_LD,
    ST_DIV,
    ST_INTP,
    ST_Q_LAST,
    ST_Q_LASTC
  } state_t;

endpackage

>>> src/polyline_arc_length_sampler_unit.sv
// Polyline arc-length sampler, top level.
// Depends on plas_pkg and plas_ram.
//
// Usage:
//  - Command channel: a transaction is taken at a rising edge with start high and
//    busy low. in_func picks clear, append, advance or query; the point and
//    time step ports are sampled with it.
//  - Result channel: only a query gives a result. It is shown for one cycle with
//    out_valid high; the receiver cannot stall it and must take it then.
//  - Config channel: cfg_valid/cfg_ready/cfg_data writes the speed register
//    (unsigned Q16.16). cfg_ready is high while the block is idle.
//  - Operation steps (one shared datapath): clear, and append to an empty or
//    full path, never raise busy; any other append runs three square/accumulate
//    passes and 32 root steps, then writes the segment length. Advance never
//    raises busy when already arrived, else does one multiply and a saturating
//    update. A query on an empty path answers without raising busy; else it
//    walks the segments, then interpolates in three passes around a 33-step
//    restoring division, or gives the last point if the distance is past the end.
//  - Items are processed one at a time; busy is high throughout every other operation.
//  - Reset (rst_n low, synchronous) empties the path, zeroes the distance, the
//    arrived flag and speed. Point memories are not cleared: an entry is read
//    only after it was written.
module polyline_arc_length_sampler_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic [23:0] in_time_step,
  output logic        out_valid,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic [31:0] out_travelled_now,
  output logic        out_reached_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int AW = plas_pkg::ADDR_W;
  localparam int CW = plas_pkg::CNT_W;

  // control state
  plas_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0]   path_r, path_nxt;
  logic [31:0]   trav_r, trav_nxt;
  logic          arrived_r, arrived_nxt;
  logic [31:0]   speed_r;
  logic          out_valid_r, out_valid_nxt;

  // datapath
  logic [31:0]   a_r [3];
  logic [31:0]   b_r [3];
  logic [31:0]   a_nxt [3];
  logic [31:0]   b_nxt [3];
  logic [31:0]   last_r [3];
  logic [31:0]   last_nxt [3];
  logic [31:0]   res_r [3];
  logic [31:0]   res_nxt [3];
  logic [1:0]    k_r, k_nxt;
  logic [32:0]   mag_r, mag_nxt;
  logic          neg_r, neg_nxt;
  logic [65:0]   prod_r;
  logic [65:0]   acc_r, acc_nxt;
  logic [34:0]   rem_r, rem_nxt;
  logic [32:0]   dq_r, dq_nxt;
  logic [31:0]   root_r, root_nxt;
  logic [5:0]    step_r, step_nxt;
  logic [CW-1:0] walk_r, walk_nxt;
  logic [31:0]   wrem_r, wrem_nxt;
  logic [31:0]   slen_r, slen_nxt;
  logic [23:0]   ts_r, ts_nxt;
  logic [31:0]   trav_out_r, trav_out_nxt;
  logic          arr_out_r, arr_out_nxt;

  // shared multiplier and subtractor
  logic [32:0]   mul_a, mul_b;
  logic [34:0]   sub_a, sub_b;
  logic [35:0]   sub_d;
  logic          sub_borrow;

  // memories
  logic          pt_we, seg_we;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   rd_x, rd_y, rd_z, rd_seg;

  logic          accept;
  plas_pkg::func_t func;

  // helpers
  logic [32:0]   diff;
  logic [40:0]   adv_sum;
  logic [31:0]   adv_sat;
  logic [32:0]   path_sum;
  logic [32:0]   intp_sum;

  assign accept    = start && (state_r == plas_pkg::ST_IDLE);
  assign busy      = (state_r != plas_pkg::ST_IDLE);
  assign cfg_ready = (state_r == plas_pkg::ST_IDLE);
  assign func      = plas_pkg::func_t'(in_func);

  assign sub_d      = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_d[35];

  assign diff     = {b_r[k_r][31], b_r[k_r]} - {a_r[k_r][31], a_r[k_r]};
  assign adv_sum  = {9'd0, trav_r} + {1'b0, prod_r[55:16]};
  assign adv_sat  = (|adv_sum[40:32]) ? 32'hFFFF_FFFF : adv_sum[31:0];
  assign path_sum = {1'b0, path_r} + {1'b0, root_r};
  assign intp_sum = neg_r ? ({a_r[k_r][31], a_r[k_r]} - dq_r)
                          : ({a_r[k_r][31], a_r[k_r]} + dq_r);

  // append writes the point straight from the ports; seg length later
  assign pt_we   = accept && (func == plas_pkg::FUNC_APPEND)
                   && (count_r < CW'(plas_pkg::MAX_POINTS));
  assign seg_we  = (state_r == plas_pkg::ST_SEG_WR);
  assign wr_addr = count_r[AW-1:0];

  always_comb begin
    case (state_r)
      plas_pkg::ST_Q_RDA:  rd_addr = AW'(walk_r - CW'(1));
      plas_pkg::ST_Q_LAST: rd_addr = AW'(count_r - CW'(1));
      default:             rd_addr = walk_r[AW-1:0];
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    case (state_r)
      plas_pkg::ST_ADV_MUL: begin
        mul_a = {1'b0, speed_r};
        mul_b = {9'd0, ts_r};
      end
      plas_pkg::ST_MUL: begin
        mul_a = mag_r;
        mul_b = (walk_r != '0) ? {1'b0, wrem_r} : mag_r;
      end
      default: begin
        mul_a = mag_r;
        mul_b = mag_r;
      end
    endcase
  end

  // operand select for the shared subtractor: root trial or divide trial
  always_comb begin
    if (state_r == plas_pkg::ST_SQRT) begin
      sub_a = {rem_r[32:0], acc_r[63:62]};
      sub_b = {1'b0, root_r, 2'b01};
    end else begin
      sub_a = {2'b00, rem_r[31:0], dq_r[32]};
      sub_b = {3'b000, slen_r};
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    path_nxt      = path_r;
    trav_nxt      = trav_r;
    arrived_nxt   = arrived_r;
    out_valid_nxt = 1'b0;
    a_nxt         = a_r;
    b_nxt         = b_r;
    last_nxt      = last_r;
    res_nxt       = res_r;
    k_nxt         = k_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    dq_nxt        = dq_r;
    root_nxt      = root_r;
    step_nxt      = step_r;
    walk_nxt      = walk_r;
    wrem_nxt      = wrem_r;
    slen_nxt      = slen_r;
    ts_nxt        = ts_r;
    trav_out_nxt  = trav_out_r;
    arr_out_nxt   = arr_out_r;

    case (state_r)
      plas_pkg::ST_IDLE: begin
        if (accept) begin
          ts_nxt = in_time_step;
          case (func)
            plas_pkg::FUNC_CLEAR: begin
              count_nxt   = '0;
              path_nxt    = '0;
              trav_nxt    = '0;
              arrived_nxt = 1'b0;
            end
            plas_pkg::FUNC_APPEND: begin
              if (count_r < CW'(plas_pkg::MAX_POINTS)) begin
                b_nxt[0] = in_point_x;
                b_nxt[1] = in_point_y;
                b_nxt[2] = in_point_z;
                if (count_r == '0) begin
                  last_nxt[0] = in_point_x;
                  last_nxt[1] = in_point_y;
                  last_nxt[2] = in_point_z;
                  count_nxt   = CW'(1);
                end else begin
                  a_nxt     = last_r;
                  k_nxt     = '0;
                  acc_nxt   = '0;
                  walk_nxt  = '0;  // zero marks append in the shared passes
                  state_nxt = plas_pkg::ST_DIFF;
                end
              end
            end
            plas_pkg::FUNC_ADVANCE: begin
              if (!arrived_r) begin
                state_nxt = plas_pkg::ST_ADV_MUL;
              end
            end
            default: begin
              trav_out_nxt = trav_r;
              arr_out_nxt  = arrived_r;
              wrem_nxt     = trav_r;
              walk_nxt     = CW'(1);
              if (count_r == '0) begin
                res_nxt[0]    = '0;
                res_nxt[1]    = '0;
                res_nxt[2]    = '0;
                out_valid_nxt = 1'b1;
              end else if (count_r == CW'(1)) begin
                state_nxt = plas_pkg::ST_Q_LAST;
              end else begin
                state_nxt = plas_pkg::ST_Q_RD;
              end
            end
          endcase
        end
      end

      plas_pkg::ST_ADV_MUL: state_nxt = plas_pkg::ST_ADV_UPD;

      plas_pkg::ST_ADV_UPD: begin
        if (adv_sat >= path_r) begin
          trav_nxt    = path_r;
          arrived_nxt = 1'b1;
        end else begin
          trav_nxt = adv_sat;
        end
        state_nxt = plas_pkg::ST_IDLE;
      end

      plas_pkg::ST_DIFF: begin
        neg_nxt   = diff[32];
        mag_nxt   = diff[32] ? (33'd0 - diff) : diff;
        state_nxt = plas_pkg::ST_MUL;
      end

      plas_pkg::ST_MUL: begin
        state_nxt = (walk_r != '0) ? plas_pkg::ST_DIV_LD : plas_pkg::ST_ACC;
      end

      plas_pkg::ST_ACC: begin
        acc_nxt = acc_r + prod_r;
        if (k_r == plas_pkg::AXIS_LAST) begin
          state_nxt = plas_pkg::ST_SQ_LD;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = plas_pkg::ST_DIFF;
        end
      end

      plas_pkg::ST_SQ_LD: begin
        rem_nxt  = '0;
        step_nxt = '0;
        if (|acc_r[65:64]) begin
          root_nxt  = 32'hFFFF_FFFF;
          state_nxt = plas_pkg::ST_SEG_WR;
        end else begin
          root_nxt  = '0;
          state_nxt = plas_pkg::ST_SQRT;
        end
      end

      plas_pkg::ST_SQRT: begin
        if (!sub_borrow) begin
          rem_nxt = sub_d[34:0];
        end else begin
          rem_nxt = sub_a;
        end
        root_nxt = {root_r[30:0], ~sub_borrow};
        acc_nxt  = {acc_r[63:0], 2'b00};
        step_nxt = step_r + 6'd1;
        if (step_r == plas_pkg::SQRT_STEPS - 6'd1) begin
          state_nxt = plas_pkg::ST_SEG_WR;
        end
      end

      plas_pkg::ST_SEG_WR: begin
        path_nxt  = path_sum[32] ? 32'hFFFF_FFFF : path_sum[31:0];
        count_nxt = count_r + CW'(1);
        last_nxt  = b_r;
        state_nxt = plas_pkg::ST_IDLE;
      end

      plas_pkg::ST_Q_RD: state_nxt = plas_pkg::ST_Q_CHK;

      plas_pkg::ST_Q_CHK: begin
        if (rd_seg > plas_pkg::SHORT_SEG_RAW && wrem_r <= rd_seg) begin
          slen_nxt  = rd_seg;
          state_nxt = plas_pkg::ST_Q_RDA;
        end else begin
          if (rd_seg > plas_pkg::SHORT_SEG_RAW) begin
            wrem_nxt = wrem_r - rd_seg;
          end
          walk_nxt = walk_r + CW'(1);
          if (walk_r + CW'(1) >= count_r) begin
            state_nxt = plas_pkg::ST_Q_LAST;
          end else begin
            state_nxt = plas_pkg::ST_Q_RD;
          end
        end
      end

      plas_pkg::ST_Q_RDA: state_nxt = plas_pkg::ST_Q_RDB;

      plas_pkg::ST_Q_RDB: begin
        a_nxt[0]  = rd_x;
        a_nxt[1]  = rd_y;
        a_nxt[2]  = rd_z;
        state_nxt = plas_pkg::ST_Q_CAPB;
      end

      plas_pkg::ST_Q_CAPB: begin
        b_nxt[0]  = rd_x;
        b_nxt[1]  = rd_y;
        b_nxt[2]  = rd_z;
        k_nxt     = '0;
        state_nxt = plas_pkg::ST_DIFF;
      end

      plas_pkg::ST_DIV_LD: begin
        rem_nxt   = {4'd0, prod_r[63:33]};
        dq_nxt    = prod_r[32:0];
        step_nxt  = '0;
        state_nxt = plas_pkg::ST_DIV;
      end

      plas_pkg::ST_DIV: begin
        if (!sub_borrow) begin
          rem_nxt = {3'd0, sub_d[31:0]};
        end else begin
          rem_nxt = {3'd0, sub_a[31:0]};
        end
        dq_nxt   = {dq_r[31:0], ~sub_borrow};
        step_nxt = step_r + 6'd1;
        if (step_r == plas_pkg::DIV_STEPS - 6'd1) begin
          state_nxt = plas_pkg::ST_INTP;
        end
      end

      plas_pkg::ST_INTP: begin
        res_nxt[k_r] = intp_sum[31:0];
        if (k_r == plas_pkg::AXIS_LAST) begin
          out_valid_nxt = 1'b1;
          state_nxt     = plas_pkg::ST_IDLE;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = plas_pkg::ST_DIFF;
        end
      end

      plas_pkg::ST_Q_LAST: state_nxt = plas_pkg::ST_Q_LASTC;

      plas_pkg::ST_Q_LASTC: begin
        res_nxt[0]    = rd_x;
        res_nxt[1]    = rd_y;
        res_nxt[2]    = rd_z;
        out_valid_nxt = 1'b1;
        state_nxt     = plas_pkg::ST_IDLE;
      end

      default: state_nxt = plas_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plas_pkg::ST_IDLE;
      count_r     <= '0;
      path_r      <= '0;
      trav_r      <= '0;
      arrived_r   <= 1'b0;
      speed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      path_r      <= path_nxt;
      trav_r      <= trav_nxt;
      arrived_r   <= arrived_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        speed_r <= cfg_data;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    last_r     <= last_nxt;
    res_r      <= res_nxt;
    k_r        <= k_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    prod_r     <= mul_a * mul_b;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    dq_r       <= dq_nxt;
    root_r     <= root_nxt;
    step_r     <= step_nxt;
    walk_r     <= walk_nxt;
    wrem_r     <= wrem_nxt;
    slen_r     <= slen_nxt;
    ts_r       <= ts_nxt;
    trav_out_r <= trav_out_nxt;
    arr_out_r  <= arr_out_nxt;
  end

  plas_ram #(.WIDTH(32), .DEPTH(plas_pkg::MAX_POINTS)) u_ram_x (
    .clk(clk), .wr_en(pt_we), .wr_addr(wr_addr), .wr_data(in_point_x),
    .rd_addr(rd_addr), .rd_data(rd_x)
  );
  plas_ram #(.WIDTH(32), .DEPTH(plas_pkg::MAX_POINTS)) u_ram_y (
    .clk(clk), .wr_en(pt_we), .wr_addr(wr_addr), .wr_data(in_point_y),
    .rd_addr(rd_addr), .rd_data(rd_y)
  );
  plas_ram #(.WIDTH(32), .DEPTH(plas_pkg::MAX_POINTS)) u_ram_z (
    .clk(clk), .wr_en(pt_we), .wr_addr(wr_addr), .wr_data(in_point_z),
    .rd_addr(rd_addr), .rd_data(rd_z)
  );
  plas_ram #(.WIDTH(32), .DEPTH(plas_pkg::MAX_POINTS)) u_ram_seg (
    .clk(clk), .wr_en(seg_we), .wr_addr(wr_addr), .wr_data(root_r),
    .rd_addr(rd_addr), .rd_data(rd_seg)
  );

  assign out_valid         = out_valid_r;
  assign out_pos_x         = res_r[0];
  assign out_pos_y         = res_r[1];
  assign out_pos_z         = res_r[2];
  assign out_travelled_now = trav_out_r;
  assign out_reached_end   = arr_out_r;

`ifndef NO_ASSERTIONS
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == plas_pkg::ST_IDLE))
    else $error("result strobe while busy");
  a_sqrt_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plas_pkg::ST_SQRT) |-> (step_r < plas_pkg::SQRT_STEPS))
    else $error("root step count out of range");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(plas_pkg::MAX_POINTS))
    else $error("point count beyond capacity");
  a_trav_le_path: assert property (@(posedge clk) disable iff (!rst_n)
    trav_r <= path_r)
    else $error("travelled distance exceeds path length");
`endif

endmodule

>>> src/plas_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module plas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> dv/polyline_arc_length_sampler_unit_test.sv
// Self-checking bench for polyline_arc_length_sampler_unit: directed table, then random paths.
// Depends on plas_pkg and the block's RTL in src; predicts query results with its own path model.
`timescale 1ns / 100ps

module polyline_arc_length_sampler_unit_test;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;

  // one query answer
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] trav;
    logic        done;
  } position_t;

  // one directed row; has_fixed marks answers typed in by hand
  typedef struct {
    plas_pkg::func_t op;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [23:0] ts;
    logic        has_fixed;
    position_t   fixed;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_func = '0;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic signed [31:0] in_point_z = '0;
  logic [23:0] in_time_step = '0;
  logic out_valid;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic [31:0] out_travelled_now;
  logic out_reached_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  polyline_arc_length_sampler_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_point_x(in_point_x), .in_point_y(in_point_y),
    .in_point_z(in_point_z), .in_time_step(in_time_step),
    .out_valid(out_valid), .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_pos_z(out_pos_z), .out_travelled_now(out_travelled_now),
    .out_reached_end(out_reached_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] speed_reg;
  logic [31:0] pt_x [plas_pkg::MAX_POINTS];
  logic [31:0] pt_y [plas_pkg::MAX_POINTS];
  logic [31:0] pt_z [plas_pkg::MAX_POINTS];
  logic [31:0] seg_len [plas_pkg::MAX_POINTS];
  int          npts;
  logic [31:0] total_len;
  logic [31:0] dist_done;
  logic        at_end;

  position_t pending_pos[$];
  int  errors = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] mag_diff(logic [31:0] a, logic [31:0] b);
    longint d;
    d = longint'($signed(b)) - longint'($signed(a));
    return d < 0 ? -d : d;
  endfunction

  function automatic logic [31:0] span_len(int i);
    logic [63:0] dx, dy, dz, s, t, r;
    logic [64:0] acc;
    dx = mag_diff(pt_x[i-1], pt_x[i]);
    dy = mag_diff(pt_y[i-1], pt_y[i]);
    dz = mag_diff(pt_z[i-1], pt_z[i]);
    acc = {1'b0, dx * dx} + {1'b0, dy * dy};
    if (acc[64]) return '1;
    s = acc[63:0];
    t = dz * dz;
    acc = {1'b0, s} + {1'b0, t};
    if (acc[64]) return '1;
    r = root64(acc[63:0]);
    return r > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  function automatic logic [31:0] lerp(logic [31:0] a, logic [31:0] b,
                                       logic [31:0] rem, logic [31:0] len);
    longint av, d;
    logic [63:0] m, off;
    av = longint'($signed(a));
    d = longint'($signed(b)) - av;
    m = d < 0 ? -d : d;
    off = (m * {32'd0, rem}) / {32'd0, len};
    return d < 0 ? 32'(av - longint'(off)) : 32'(av + longint'(off));
  endfunction

  // update path state; returns 1 with the position for a query
  function automatic bit path_step(plas_pkg::func_t op, logic [31:0] px, logic [31:0] py,
                                   logic [31:0] pz, logic [23:0] ts,
                                   output position_t p);
    logic [63:0] inc;
    logic [32:0] sum;
    logic [31:0] rem, l;
    bit hit;
    p = '0;
    case (op)
      plas_pkg::FUNC_CLEAR: begin
        npts = 0; total_len = 0; dist_done = 0; at_end = 0;
        return 0;
      end
      plas_pkg::FUNC_APPEND: begin
        if (npts >= plas_pkg::MAX_POINTS) return 0;
        pt_x[npts] = px; pt_y[npts] = py; pt_z[npts] = pz;
        if (npts > 0) begin
          l = span_len(npts);
          seg_len[npts] = l;
          sum = {1'b0, total_len} + {1'b0, l};
          total_len = sum[32] ? '1 : sum[31:0];
        end else begin
          seg_len[0] = 0;
        end
        npts++;
        return 0;
      end
      plas_pkg::FUNC_ADVANCE: begin
        if (at_end) return 0;
        inc = ({32'd0, speed_reg} * {40'd0, ts}) >> 16;
        sum = {1'b0, dist_done} + inc[32:0];
        dist_done = (sum[32] || inc[63:32] != 0) ? '1 : sum[31:0];
        if (dist_done >= total_len) begin
          dist_done = total_len;
          at_end = 1;
        end
        return 0;
      end
      default: begin
        hit = 0;
        if (npts > 0) begin
          rem = dist_done;
          for (int i = 1; i < npts; i++) begin
            l = seg_len[i];
            if (l <= plas_pkg::SHORT_SEG_RAW) continue;
            if (rem <= l) begin
              p.x = lerp(pt_x[i-1], pt_x[i], rem, l);
              p.y = lerp(pt_y[i-1], pt_y[i], rem, l);
              p.z = lerp(pt_z[i-1], pt_z[i], rem, l);
              hit = 1;
              break;
            end
            rem -= l;
          end
          if (!hit) begin
            p.x = pt_x[npts-1]; p.y = pt_y[npts-1]; p.z = pt_z[npts-1];
          end
        end
        p.trav = dist_done;
        p.done = at_end;
        return 1;
      end
    endcase
  endfunction

  // check each result against the oldest expected position
  always @(posedge clk) begin
    position_t e;
    if (rst_n && out_valid) begin
      if (pending_pos.size() == 0) begin
        $display("%0t unexpected result x=%h", $time, out_pos_x);
        errors++;
      end else begin
        e = pending_pos.pop_front();
        if (out_pos_x !== e.x) begin
          $display("%0t pos_x exp %h got %h", $time, e.x, out_pos_x); errors++;
        end
        if (out_pos_y !== e.y) begin
          $display("%0t pos_y exp %h got %h", $time, e.y, out_pos_y); errors++;
        end
        if (out_pos_z !== e.z) begin
          $display("%0t pos_z exp %h got %h", $time, e.z, out_pos_z); errors++;
        end
        if (out_travelled_now !== e.trav) begin
          $display("%0t travelled exp %h got %h", $time, e.trav, out_travelled_now);
          errors++;
        end
        if (out_reached_end !== e.done) begin
          $display("%0t reached_end exp %b got %b", $time, e.done, out_reached_end);
          errors++;
        end
      end
    end
  end

  // watchdog: count cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // send one command transaction; fixed answer overrides the predictor when given.
  // start stays high afterwards until the next command or a drain lowers it.
  task automatic send_cmd(plas_pkg::func_t op, logic [31:0] px, logic [31:0] py,
                          logic [31:0] pz, logic [23:0] ts, bit use_fixed,
                          position_t fixed);
    position_t p;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_func <= op;
    in_point_x <= px; in_point_y <= py; in_point_z <= pz;
    in_time_step <= ts;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (path_step(op, px, py, pz, ts, p))
      pending_pos.insert(pending_pos.size(), use_fixed ? fixed : p);
    @(negedge clk);
  endtask

  // wait for every expected result, then let the datapath settle
  task automatic drain();
    start <= 1'b0;
    while (pending_pos.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_speed(logic [31:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    speed_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(1, 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(2000, 0)) - 1000) <<< 8;
      default: return 32'($signed($urandom_range(20, 0)) - 10);
    endcase
  endfunction

  // one well-formed path: clear, points, then queries mixed with advances and some appends
  task automatic random_path(ref int left);
    int n, mode;
    position_t nofix;
    nofix = '0;
    send_cmd(plas_pkg::FUNC_CLEAR, $urandom, $urandom, $urandom, 24'($urandom), 0, nofix);
    left--;
    n = ($urandom_range(9, 0) == 0) ? $urandom_range(plas_pkg::MAX_POINTS + 2, 40)
                                    : $urandom_range(8, 0);
    mode = $urandom_range(3, 0);
    for (int i = 0; i < n && left > 0; i++, left--)
      send_cmd(plas_pkg::FUNC_APPEND, rand_coord(mode), rand_coord(mode), rand_coord(mode),
               24'($urandom), 0, nofix);
    for (int i = 0; i < 10 && left > 0; i++, left--) begin
      if ($urandom_range(1, 0))
        send_cmd(plas_pkg::FUNC_QUERY, $urandom, $urandom, $urandom, 24'($urandom), 0,
                 nofix);
      else if ($urandom_range(7, 0) == 0)
        send_cmd(plas_pkg::FUNC_APPEND, rand_coord(mode), rand_coord(mode),
                 rand_coord(mode), 24'($urandom), 0, nofix);
      else
        send_cmd(plas_pkg::FUNC_ADVANCE, $urandom, $urandom, $urandom, 24'($urandom), 0,
                 nofix);
    end
  endtask

  row_t rows[$];

  task automatic add_row(row_t r);
    rows.insert(rows.size(), r);
  endtask

  initial begin
    position_t p0, nofix;
    int left;
    logic [31:0] speeds[4];
    speed_reg = 0; npts = 0; total_len = 0; dist_done = 0; at_end = 0;
    nofix = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty path, arrival on it, extremes, a single point, short segments
    p0 = '0;
    add_row('{plas_pkg::FUNC_QUERY, 0, 0, 0, 0, 1, p0});
    add_row('{plas_pkg::FUNC_ADVANCE, 0, 0, 0, 24'hFFFFFF, 0, p0});
    p0.done = 1;
    add_row('{plas_pkg::FUNC_QUERY, 0, 0, 0, 0, 1, p0});
    add_row('{plas_pkg::FUNC_CLEAR, '1, '1, '1, '1, 0, p0});
    add_row('{plas_pkg::FUNC_APPEND, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, p0});
    add_row('{plas_pkg::FUNC_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, p0});
    add_row('{plas_pkg::FUNC_QUERY, 0, 0, 0, 0, 1,
              '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0}});
    add_row('{plas_pkg::FUNC_APPEND, 32'h7FFF_FFFB, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, p0});
    add_row('{plas_pkg::FUNC_APPEND, 0, 0, 0, 0, 0, p0});
    add_row('{plas_pkg::FUNC_ADVANCE, 0, 0, 0, 24'h000001, 0, p0});
    add_row('{plas_pkg::FUNC_QUERY, 0, 0, 0, 0, 0, p0});
    add_row('{plas_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, p0});
    add_row('{plas_pkg::FUNC_APPEND, 32'h0001_0000, 0, 0, 0, 0, p0});
    add_row('{plas_pkg::FUNC_QUERY, 0, 0, 0, 0, 1, '{32'h0001_0000, 0, 0, 0, 0}});
    add_row('{plas_pkg::FUNC_APPEND, 32'h0001_0006, 0, 0, 0, 0, p0});
    add_row('{plas_pkg::FUNC_APPEND, 32'h0005_0006, 32'hFFFD_0000, 0, 0, 0, p0});
    add_row('{plas_pkg::FUNC_QUERY, 0, 0, 0, 0, 0, p0});
    foreach (rows[i])
      send_cmd(rows[i].op, rows[i].px, rows[i].py, rows[i].pz, rows[i].ts,
               rows[i].has_fixed, rows[i].fixed);

    // speed extremes and mid values, three idling phases
    speeds = '{32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0001, 32'h0040_0000};
    left = 1750;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 69 : 0;
      for (int k = 0; k < 4 && left > 0; k++) begin
        write_speed(($urandom_range(3, 0) == 0) ? $urandom : speeds[k]);
        for (int j = 0; j < 9 && left > 0; j++) random_path(left);
        // hold off until every expected result has come
        drain();
        send_cmd(plas_pkg::FUNC_QUERY, $urandom, $urandom, $urandom, 24'($urandom), 0,
                 nofix);
        left--;
      end
    end
    // write zero speed last, then exercise it
    write_speed(32'd0);
    random_path(left);

    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
src/plas_pkg.sv
src/plas_ram.sv
src/polyline_arc_length_sampler_unit.sv
dv/polyline_arc_length_sampler_unit_test.sv
